// File: rtl/pil_pkg.sv
// shared types and codes for the positional insert list
`timescale 1ns / 1ps

package pil_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_EXPAND = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_SHIFT  = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_TAIL   = 2'd3
  } cmd_t;

endpackage

// File: rtl/pil_cell.sv
// one list slot of the cell chain
`timescale 1ns / 1ps

module pil_cell #(
  parameter int INDEX = 0,
  parameter int CMP_W = 5
) (
  input  logic                         clk,
  input  pil_pkg::cmd_t                cmd,
  input  logic [CMP_W-1:0]             pos,
  input  logic [CMP_W-1:0]             count,
  input  logic [pil_pkg::DATA_W-1:0]   data,
  input  logic [pil_pkg::DATA_W-1:0]   left,
  input  logic [pil_pkg::DATA_W-1:0]   right,
  input  logic [pil_pkg::DATA_W-1:0]   head,
  output logic [pil_pkg::DATA_W-1:0]   q
);

  localparam logic [CMP_W-1:0] IDX    = CMP_W'(INDEX);
  localparam logic [CMP_W-1:0] IDX_P1 = CMP_W'(INDEX + 1);

  always_ff @(posedge clk) begin
    case (cmd)
      pil_pkg::CMD_SHIFT: begin
        // open a slot at pos, everything behind moves one toward the tail
        if (IDX == pos) begin
          q <= data;
        end else if (IDX > pos) begin
          q <= left;
        end
      end
      pil_pkg::CMD_ROTATE: begin
        // head leaves, the rest moves up, head lands in the tail slot
        if (IDX_P1 < count) begin
          q <= right;
        end else if (IDX_P1 == count) begin
          q <= head;
        end
      end
      pil_pkg::CMD_TAIL: begin
        if (IDX == count) begin
          q <= data;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

// File: rtl/positional_insert_list_core.sv
// top level of the positional insert list: control sequencer and cell chain
`timescale 1ns / 1ps

// channel   | signals                                   | transfer when
// ----------+-------------------------------------------+---------------------
// command   | start, busy, operation, value, position   | start && !busy
// result    | strobe, status, element, has_element, last | strobe (one cycle)
//
// insert and append show their result the cycle after acceptance, and busy
// stays low so another command can follow at once.
// dump emits one entry per cycle (one bare result for an empty list) as the
// chain rotates once around; expand odd rotates each entry past the head and
// writes a square at the tail behind each odd entry it meets while there is room.
// rst is synchronous and empties the list; no clearing pass is needed.
// the receiver cannot stall: each result is shown for exactly one cycle.

module positional_insert_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [pil_pkg::OP_W-1:0]            operation,
  input  logic signed [pil_pkg::DATA_W-1:0]   value,
  input  logic [pil_pkg::POS_W-1:0]           position,
  output logic                                strobe,
  output logic [pil_pkg::STATUS_W-1:0]        status,
  output logic signed [pil_pkg::DATA_W-1:0]   element,
  output logic                                has_element,
  output logic                                last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > pil_pkg::POS_W) ? CNT_W : pil_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DUMP,
    S_EXP,
    S_SQ
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              count;     // stored entries
  logic [CNT_W-1:0]              idx;       // dump position
  logic [CNT_W-1:0]              remain;    // entries left to scan in expand
  logic                          full_hit;  // expand met an odd entry on a full list
  logic [pil_pkg::DATA_W-1:0]    square;

  logic                          accept;
  logic [pil_pkg::STATUS_W-1:0]  ins_status;
  logic [CMP_W-1:0]              pos_ext;
  logic [CMP_W-1:0]              count_ext;

  pil_pkg::cmd_t                 cmd;
  logic [CMP_W-1:0]              cmd_pos;
  logic [pil_pkg::DATA_W-1:0]    cmd_data;

  logic [pil_pkg::DATA_W-1:0]    cell_q [CAPACITY];
  logic [pil_pkg::DATA_W-1:0]    head;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign pos_ext   = CMP_W'(position);
  assign count_ext = CMP_W'(count);
  assign head      = cell_q[0];

  // range check has priority over the full check
  always_comb begin
    if ((operation == pil_pkg::OP_INSERT) && (pos_ext > count_ext)) begin
      ins_status = pil_pkg::ST_RANGE;
    end else if (count == CAP_CNT) begin
      ins_status = pil_pkg::ST_FULL;
    end else begin
      ins_status = pil_pkg::ST_OK;
    end
  end

  // command to the chain for this cycle
  always_comb begin
    cmd      = pil_pkg::CMD_HOLD;
    cmd_pos  = pos_ext;
    cmd_data = square;
    case (state)
      S_IDLE: begin
        if (accept && ins_status == pil_pkg::ST_OK &&
            (operation == pil_pkg::OP_INSERT || operation == pil_pkg::OP_APPEND)) begin
          cmd      = pil_pkg::CMD_SHIFT;
          cmd_data = value;
          // append is an insert at the tail
          cmd_pos  = (operation == pil_pkg::OP_APPEND) ? count_ext : pos_ext;
        end
      end
      S_DUMP: begin
        cmd = pil_pkg::CMD_ROTATE;
      end
      S_EXP: begin
        if (remain != '0) begin
          cmd = pil_pkg::CMD_ROTATE;
        end
      end
      S_SQ: begin
        cmd = pil_pkg::CMD_TAIL;
      end
      default: begin
        cmd = pil_pkg::CMD_HOLD;
      end
    endcase
  end

  // sequencer and registered result port
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      full_hit <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              pil_pkg::OP_INSERT, pil_pkg::OP_APPEND: begin
                strobe      <= 1'b1;
                status      <= ins_status;
                element     <= '0;
                has_element <= 1'b0;
                last        <= 1'b1;
                if (ins_status == pil_pkg::ST_OK) begin
                  count <= count + CNT_W'(1);
                end
              end
              pil_pkg::OP_DUMP: begin
                if (count == '0) begin
                  // empty list gives one result with no entry
                  strobe      <= 1'b1;
                  status      <= pil_pkg::ST_OK;
                  element     <= '0;
                  has_element <= 1'b0;
                  last        <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= S_DUMP;
                end
              end
              pil_pkg::OP_EXPAND: begin
                remain   <= count;
                full_hit <= 1'b0;
                state    <= S_EXP;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DUMP: begin
          // head goes out while the chain rotates it to the tail
          strobe      <= 1'b1;
          status      <= pil_pkg::ST_OK;
          element     <= head;
          has_element <= 1'b1;
          last        <= ((idx + CNT_W'(1)) == count);
          idx         <= idx + CNT_W'(1);
          if ((idx + CNT_W'(1)) == count) begin
            state <= S_IDLE;
          end
        end
        S_EXP: begin
          if (remain == '0) begin
            strobe      <= 1'b1;
            status      <= full_hit ? pil_pkg::ST_FULL : pil_pkg::ST_OK;
            element     <= '0;
            has_element <= 1'b0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            remain <= remain - CNT_W'(1);
            // after full, the rest only rotates back into place
            if (head[0] && !full_hit) begin
              if (count == CAP_CNT) begin
                full_hit <= 1'b1;
              end else begin
                square <= head * head;
                state  <= S_SQ;
              end
            end
          end
        end
        S_SQ: begin
          // square lands right behind its odd entry at the tail
          count <= count + CNT_W'(1);
          state <= S_EXP;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // chain of cells, each talking to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pil_pkg::DATA_W-1:0] left_d;
    logic [pil_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = cmd_data;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = head;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    pil_cell #(
      .INDEX (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (cmd_pos),
      .count (count_ext),
      .data  (cmd_data),
      .left  (left_d),
      .right (right_d),
      .head  (head),
      .q     (cell_q[i])
    );
  end

endmodule

// File: rtl/pil_checker.sv
// port-level checks for the positional insert list, bound to the top level
`timescale 1ns / 1ps

module pil_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [pil_pkg::OP_W-1:0]            operation,
  input logic                                strobe,
  input logic [pil_pkg::STATUS_W-1:0]        status,
  input logic signed [pil_pkg::DATA_W-1:0]   element,
  input logic                                has_element,
  input logic                                last
);

  // insert and append answer in the very next cycle with a single result
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy &&
    (operation == pil_pkg::OP_INSERT || operation == pil_pkg::OP_APPEND)
    |=> strobe && last && !has_element)
    else $error("insert or append did not answer next cycle");

  // entries only come out of a dump, which always reports ok
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && has_element |-> status == pil_pkg::ST_OK)
    else $error("entry result with error status");

  // results without an entry carry zero
  a_zero_element: assert property (@(posedge clk) disable iff (rst)
    strobe && !has_element |-> element == '0)
    else $error("element nonzero without entry");

  // more results are coming, so the block must still be busy
  a_busy_midway: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("not busy before last result");

endmodule

bind positional_insert_list_core pil_checker u_pil_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .operation   (operation),
  .strobe      (strobe),
  .status      (status),
  .element     (element),
  .has_element (has_element),
  .last        (last)
);

// File: verif/testbench.sv
// self-checking testbench for the positional insert list core
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_DEPTH     = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  // longest walk of one command: expand rotates every entry and writes a square per odd entry
  localparam int DRAIN_CYCLES   = 2 * LIST_DEPTH + 8;

  // one result transfer as seen on the result ports
  typedef struct packed {
    logic [pil_pkg::STATUS_W-1:0] status;
    logic [pil_pkg::DATA_W-1:0]   element;
    logic                         has_element;
    logic                         last;
  } list_result_t;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic [pil_pkg::OP_W-1:0]            operation;
  logic signed [pil_pkg::DATA_W-1:0]   value;
  logic [pil_pkg::POS_W-1:0]           position;
  logic                                strobe;
  logic [pil_pkg::STATUS_W-1:0]        status;
  logic signed [pil_pkg::DATA_W-1:0]   element;
  logic                                has_element;
  logic                                last;

  // shadow copy of the list contents, updated at every command transfer
  logic [pil_pkg::DATA_W-1:0] list_mem [LIST_DEPTH];
  int                         list_len;

  // results the block still owes, oldest first
  list_result_t pending_results[$];

  int mismatch_count;
  int quiet_cycles;
  bit allow_idle;

  positional_insert_list_core #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .value      (value),
    .position   (position),
    .strobe     (strobe),
    .status     (status),
    .element    (element),
    .has_element(has_element),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // list model
  // ---------------------------------------------------------------------------

  function automatic void push_result(logic [pil_pkg::STATUS_W-1:0] st,
                                      logic [pil_pkg::DATA_W-1:0] elem,
                                      logic has, logic fin);
    list_result_t r;
    r.status      = st;
    r.element     = elem;
    r.has_element = has;
    r.last        = fin;
    pending_results.push_back(r);
  endfunction

  // open a slot at index at (caller guarantees room) and store v there
  function automatic void open_slot(int at, logic [pil_pkg::DATA_W-1:0] v);
    int i;
    for (i = list_len; i > at; i--)
      list_mem[i] = list_mem[i-1];
    list_mem[at] = v;
    list_len++;
  endfunction

  function automatic int odd_entries();
    int i;
    int n;
    n = 0;
    for (i = 0; i < list_len; i++)
      if (list_mem[i][0]) n++;
    return n;
  endfunction

  // apply one accepted command to the shadow list and queue the results it owes
  function automatic void apply_list_op(pil_pkg::op_t op, logic [pil_pkg::DATA_W-1:0] val,
                                        logic [pil_pkg::POS_W-1:0] pos);
    logic [pil_pkg::STATUS_W-1:0] st;
    logic [pil_pkg::DATA_W-1:0]   sq;
    int                           i;
    st = pil_pkg::ST_OK;
    case (op)
      pil_pkg::OP_DUMP: begin
        // an empty list still answers with one bare result
        if (list_len == 0)
          push_result(pil_pkg::ST_OK, '0, 1'b0, 1'b1);
        else
          for (i = 0; i < list_len; i++)
            push_result(pil_pkg::ST_OK, list_mem[i], 1'b1, i == list_len - 1);
        return;
      end
      pil_pkg::OP_INSERT: begin
        // range is checked ahead of the full check
        if (pos > list_len)
          st = pil_pkg::ST_RANGE;
        else if (list_len >= LIST_DEPTH)
          st = pil_pkg::ST_FULL;
        else
          open_slot(int'(pos), val);
      end
      pil_pkg::OP_APPEND: begin
        if (list_len >= LIST_DEPTH)
          st = pil_pkg::ST_FULL;
        else
          open_slot(list_len, val);
      end
      default: begin
        // square follows each odd entry and is skipped; an odd entry met on a
        // full list ends the pass, squares already written stay
        i = 0;
        while (i < list_len) begin
          if (list_mem[i][0]) begin
            if (list_len >= LIST_DEPTH) begin
              st = pil_pkg::ST_FULL;
              break;
            end
            sq = list_mem[i] * list_mem[i];
            open_slot(i + 1, sq);
            i += 2;
          end else begin
            i++;
          end
        end
      end
    endcase
    push_result(st, '0, 1'b0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // random data word, leaning on the sign and magnitude corners now and then
  function automatic logic [pil_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // one command transfer; start stays high afterwards unless the next call idles
  task automatic send_cmd(input pil_pkg::op_t op, input logic [pil_pkg::DATA_W-1:0] val,
                          input logic [pil_pkg::POS_W-1:0] pos);
    if (allow_idle) begin
      while ($urandom_range(99) < 27) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start     <= 1'b1;
    operation <= op;
    value     <= val;
    position  <= pos;
    // busy is sampled at the edge itself, before the block updates it
    do
      @(posedge clk);
    while (busy !== 1'b0);
    apply_list_op(op, val, pos);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // the receiver cannot stall, so every strobed cycle is a result transfer
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d element %h last %b",
                                  status, element, last));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (element !== want.element)
          report_mismatch($sformatf("element %h, expected %h", element, want.element));
        if (has_element !== want.has_element)
          report_mismatch($sformatf("has_element %b, expected %b", has_element,
                                    want.has_element));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
      end
    end
  end

  // ends a hung run: counts cycles with neither a command nor a result transfer
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // dump, insert and expand on an empty list, range errors at the low and top positions
  task automatic test_empty_list();
    send_cmd(pil_pkg::OP_DUMP, 32'h0000_0000, 5'd0);
    send_cmd(pil_pkg::OP_INSERT, 32'h1234_5678, 5'd1);
    send_cmd(pil_pkg::OP_INSERT, 32'hffff_ffff, 5'd31);
    send_cmd(pil_pkg::OP_EXPAND, 32'h0000_0000, 5'd31);
  endtask

  // head, middle and tail inserts with the data corners, then a range error and a dump
  task automatic test_field_extremes();
    send_cmd(pil_pkg::OP_INSERT, 32'h8000_0000, 5'd0);
    send_cmd(pil_pkg::OP_APPEND, 32'h7fff_ffff, 5'd31);
    send_cmd(pil_pkg::OP_APPEND, 32'hffff_ffff, 5'd0);
    send_cmd(pil_pkg::OP_INSERT, 32'h0000_0001, 5'd1);
    send_cmd(pil_pkg::OP_INSERT, 32'h0000_0000, 5'(list_len));
    send_cmd(pil_pkg::OP_INSERT, 32'h0000_0002, 5'd0);
    send_cmd(pil_pkg::OP_INSERT, 32'h0000_0007, 5'(list_len + 1));
    send_cmd(pil_pkg::OP_DUMP, 32'h0000_0000, 5'd0);
  endtask

  // odd entries include a negative one and the largest positive value
  task automatic test_expand_odd();
    send_cmd(pil_pkg::OP_EXPAND, 32'hdead_beef, 5'd16);
    send_cmd(pil_pkg::OP_DUMP, 32'h0000_0000, 5'd0);
  endtask

  // the list only grows, so growth is rationed to leave room for the full tests;
  // most commands are dumps and range errors on lists of every size on the way
  task automatic test_random_growth(input int n_items);
    int                         k;
    int                         r;
    logic [pil_pkg::DATA_W-1:0] v;
    logic [pil_pkg::POS_W-1:0]  p;
    for (k = 0; k < n_items; k++) begin
      allow_idle = !(k >= 100 && k < 220);
      r = $urandom_range(99);
      v = pick_value();
      p = pil_pkg::POS_W'($urandom_range(31));
      if (r < 4 && list_len < LIST_DEPTH - 3) begin
        if ($urandom_range(99) < 60) v[0] = 1'b0;
        r = $urandom_range(99);
        if (r < 50)
          send_cmd(pil_pkg::OP_INSERT, v, 5'($urandom_range(list_len)));
        else if (r < 80 || list_len + odd_entries() > LIST_DEPTH - 3)
          send_cmd(pil_pkg::OP_APPEND, v, p);
        else
          send_cmd(pil_pkg::OP_EXPAND, v, p);
      end else if (r < 45) begin
        send_cmd(pil_pkg::OP_DUMP, v, p);
      end else if (r < 85) begin
        send_cmd(pil_pkg::OP_INSERT, v, 5'($urandom_range(31, list_len + 1)));
      end else begin
        // first position past the tail
        send_cmd(pil_pkg::OP_INSERT, v, 5'(list_len + 1));
      end
    end
    allow_idle = 1'b1;
  endtask

  // expand runs out of room part way, then every way of hitting a full list
  task automatic test_full_list();
    while (list_len < LIST_DEPTH - 2)
      send_cmd(pil_pkg::OP_APPEND, pick_value() | 32'd1, 5'($urandom_range(31)));
    send_cmd(pil_pkg::OP_EXPAND, pick_value(), 5'd0);
    send_cmd(pil_pkg::OP_DUMP, pick_value(), 5'd0);
    send_cmd(pil_pkg::OP_INSERT, pick_value(), 5'(LIST_DEPTH));
    send_cmd(pil_pkg::OP_INSERT, pick_value(), 5'(LIST_DEPTH + 1));
    send_cmd(pil_pkg::OP_INSERT, pick_value(), 5'd0);
    send_cmd(pil_pkg::OP_APPEND, pick_value(), 5'd0);
    send_cmd(pil_pkg::OP_EXPAND, pick_value(), 5'd0);
    send_cmd(pil_pkg::OP_DUMP, pick_value(), 5'd0);
  endtask

  // unrestricted commands once nothing can change any more
  task automatic test_random_full(input int n_items);
    int k;
    for (k = 0; k < n_items; k++)
      send_cmd(pil_pkg::op_t'($urandom_range(3)), pick_value(), 5'($urandom_range(31)));
  endtask

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    operation      <= pil_pkg::OP_INSERT;
    value          <= '0;
    position       <= '0;
    list_len       = 0;
    allow_idle     = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_field_extremes();
    test_expand_odd();
    test_random_growth(380);
    test_full_list();
    test_random_full(60);

    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    // catch anything extra the block might still emit
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
